// ===== design/assert_macros.svh =====
// Assertion macros used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lpcp_pkg.sv =====
// Types, keyword table and constants of the length-prefixed command parser
package lpcp_pkg;

	typedef enum logic [2:0] {
		KIND_SPEED    = 3'd0,
		KIND_GEAR     = 3'd1,
		KIND_RPM      = 3'd2,
		KIND_UNKNOWN  = 3'd3,
		KIND_LEN_ERR  = 3'd4,
		KIND_OVERFLOW = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0]  alive;
		phase_t      phase;
		logic        negative;
		logic [30:0] magnitude;
		logic        ended;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		alive:     3'b111,
		phase:     PH_SKIP,
		negative:  1'b0,
		magnitude: 31'd0,
		ended:     1'b0
	};

	localparam int NUM_KW     = 3;
	localparam int KW_MAX_LEN = 9;

	localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd9, 8'd5, 8'd4};

	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{"s", "p", "e", "e", "d", "K", "m", "h", ":"},
		'{"g", "e", "a", "r", ":", 8'd0, 8'd0, 8'd0, 8'd0},
		'{"r", "p", "m", ":", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
	};

	localparam logic [7:0] CHR_NL    = 8'd10;
	localparam logic [7:0] CHR_NUL   = 8'd0;
	localparam logic [7:0] CHR_PLUS  = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;
	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam logic [7:0] CHR_NINE  = 8'd57;
	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_TAB   = 8'd9;
	localparam logic [7:0] CHR_CR    = 8'd13;

	// -('0' * 10 + '0') folds to -528, which is 240 modulo 256
	localparam logic [7:0] LEN_OFFSET  = 8'd240;
	localparam logic [7:0] LIMIT_RESET = 8'd150;
	localparam logic [2:0] ADDR_LIMIT  = 3'd0;

endpackage

// ===== design/lpcp_content.sv =====
// Keyword match and atoi-style number update for one command byte
module lpcp_content (
	input  lpcp_pkg::parse_t cur,
	input  logic [7:0]       pos,
	input  logic [7:0]       rx,
	output lpcp_pkg::parse_t nxt
);
	import lpcp_pkg::*;

	logic        fed;
	logic        is_digit;
	logic        is_space;
	logic [34:0] prod;

	assign is_digit = rx inside {[CHR_ZERO:CHR_NINE]};
	assign is_space = rx inside {CHR_SPACE, [CHR_TAB:CHR_CR]};
	assign prod = ({4'd0, cur.magnitude} << 3) + ({4'd0, cur.magnitude} << 1)
		+ {31'd0, rx[3:0] - CHR_ZERO[3:0]};

	always_comb begin
		logic accumulate;
		nxt = cur;
		fed = 1'b0;
		accumulate = 1'b0;
		if (!cur.ended) begin
			if (rx == CHR_NUL) begin
				// too short for a keyword still pending: drop it
				for (int k = 0; k < NUM_KW; k++) begin
					if (pos < KW_LEN[k])
						nxt.alive[k] = 1'b0;
				end
				nxt.ended = 1'b1;
			end else begin
				for (int k = 0; k < NUM_KW; k++) begin
					if (!fed && cur.alive[k]) begin
						if (pos < KW_LEN[k]) begin
							if (KW_TEXT[k][pos[3:0]] != rx)
								nxt.alive[k] = 1'b0;
						end else begin
							fed = 1'b1;
						end
					end
				end
				if (fed) begin
					case (cur.phase)
						PH_SKIP: begin
							if (is_space) begin
								nxt.phase = PH_SKIP;
							end else if (rx == CHR_PLUS || rx == CHR_MINUS) begin
								nxt.negative = (rx == CHR_MINUS);
								nxt.phase = PH_DIGITS;
							end else if (is_digit) begin
								nxt.phase = PH_DIGITS;
								accumulate = 1'b1;
							end else begin
								nxt.phase = PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit)
								accumulate = 1'b1;
							else
								nxt.phase = PH_DONE;
						end
						default: nxt.phase = cur.phase;
					endcase
					if (accumulate)
						nxt.magnitude = (prod[34:31] != 4'd0) ? {31{1'b1}} : prod[30:0];
				end
			end
		end
	end

endmodule

// ===== design/length_prefixed_command_parser_top.sv =====
// Top level of the length-prefixed command parser
//
// Usage: bytes arrive on rx_byte with in_valid/in_ready; each transfer is one
// received byte. The first two bytes form a two-digit length (ASCII, modulo
// 256); a length at or above buffer_limit gives a length-error result. Then
// the command bytes follow up to a newline, which gives one result on
// kind/value (speed, gear, rpm with its number, or unknown). Too many command
// bytes give an overflow result and the parser reads a new length.
// Results leave on out_valid/out_ready; most bytes give no result.
// A byte is taken into an input register, parsed from there, and its result,
// if any, is written into the result register.
// Throughput: one byte per cycle while results are taken; the per-byte
// parse is a single step of short logic between input and result register.
// A stalled receiver holds the result register; the input register then
// holds one byte and in_ready drops until the result is taken.
// Reset clears the parser to the length phase and buffer_limit to 150.
// The APB port holds buffer_limit at address 0; write it only when idle.
`include "assert_macros.svh"

module length_prefixed_command_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic signed [31:0] value,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lpcp_pkg::*;

	logic [7:0]  limit_q;
	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        adv;

	logic        in_command_q, in_command_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  first_digit_q, first_digit_d;
	parse_t      parse_q, parse_d, parse_fed;

	logic        res_valid;
	kind_t       res_kind;
	logic [31:0] res_value;
	logic [7:0]  len;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [31:0] value_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_LIMIT[2]) ? {24'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && paddr[2] == ADDR_LIMIT[2])
			limit_q <= pwdata[7:0];
	end

	// input register: advance when the result slot is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			rx_byte_s1 <= rx_byte;
	end

	lpcp_content u_content (
		.cur (parse_q),
		.pos (byte_count_q),
		.rx  (rx_byte_s1),
		.nxt (parse_fed)
	);

	assign len = first_digit_q * 8'd10 + rx_byte_s1 + LEN_OFFSET;

	always_comb begin
		in_command_d  = in_command_q;
		byte_count_d  = byte_count_q;
		first_digit_d = first_digit_q;
		parse_d       = parse_q;
		res_valid     = 1'b0;
		res_kind      = KIND_UNKNOWN;
		res_value     = 32'd0;
		if (!in_command_q) begin
			if (byte_count_q == 8'd0) begin
				first_digit_d = rx_byte_s1;
				byte_count_d  = 8'd1;
			end else begin
				byte_count_d = 8'd0;
				parse_d      = PARSE_CLEAR;
				if (len >= limit_q) begin
					res_valid = 1'b1;
					res_kind  = KIND_LEN_ERR;
				end else begin
					in_command_d = 1'b1;
				end
			end
		end else if (rx_byte_s1 == CHR_NL) begin
			res_valid = 1'b1;
			// first keyword that is still alive and complete wins
			for (int k = NUM_KW - 1; k >= 0; k--) begin
				if (parse_q.alive[k] && (parse_q.ended || byte_count_q >= KW_LEN[k])) begin
					res_kind  = kind_t'(k[2:0]);
					res_value = parse_q.negative ? (32'd0 - {1'b0, parse_q.magnitude})
						: {1'b0, parse_q.magnitude};
				end
			end
			in_command_d = 1'b0;
			byte_count_d = 8'd0;
			parse_d      = PARSE_CLEAR;
		end else if (limit_q != 8'd0 && byte_count_q < limit_q - 8'd1) begin
			parse_d      = parse_fed;
			byte_count_d = byte_count_q + 8'd1;
		end else begin
			// drop the byte and go back to reading a length
			res_valid    = 1'b1;
			res_kind     = KIND_OVERFLOW;
			in_command_d = 1'b0;
			byte_count_d = 8'd0;
			parse_d      = PARSE_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_command_q  <= 1'b0;
			byte_count_q  <= 8'd0;
			first_digit_q <= 8'd0;
			parse_q       <= PARSE_CLEAR;
		end else if (adv) begin
			in_command_q  <= in_command_d;
			byte_count_q  <= byte_count_d;
			first_digit_q <= first_digit_d;
			parse_q       <= parse_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && res_valid)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			kind_q  <= res_kind;
			value_q <= res_value;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;

	`ASSERT_IMPLIES(a_len_count, !in_command_q, byte_count_q <= 8'd1, "length phase count above one")
	`ASSERT_IMPLIES(a_sign_phase, parse_q.negative, parse_q.phase != PH_SKIP, "sign seen while skipping")
	`ASSERT_IMPLIES(a_one_keyword, in_command_q && byte_count_q != 8'd0, $onehot0(parse_q.alive), "several keywords alive")
	`ASSERT_IMPLIES(a_plain_value, out_valid_q && (kind_q == KIND_UNKNOWN || kind_q == KIND_LEN_ERR || kind_q == KIND_OVERFLOW), value_q == 32'd0, "value on non-numeric result")

endmodule
